// ===== src/rlcb_pkg.sv =====
// Shared types, codes and constants of the round lens crosshair blend.
package rlcb_pkg;

  // Default geometry of the lens and its crosshair.
  localparam int LENS_SIZE_DEF     = 256;
  localparam int ARM_THICKNESS_DEF = 8;
  localparam int CENTER_GAP_DEF    = 20;
  localparam int EDGE_MARGIN_DEF   = 8;

  // Mark class codes as reported on the result channel.
  localparam logic [1:0] MARK_NONE    = 2'd0;
  localparam logic [1:0] MARK_ARM     = 2'd1;
  localparam logic [1:0] MARK_CONTOUR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LENS_LEFT    = 3'd0;
  localparam logic [2:0] CFG_LENS_TOP     = 3'd1;
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_MARK_ALPHA   = 3'd4;

  // Width of a signed window-local coordinate that also holds every arm box
  // bound, including the grown contour bounds.
  function automatic int coord_w(input int lens_size, input int edge_margin,
                                 input int center_gap);
    coord_w = $clog2(lens_size + edge_margin + center_gap + 2) + 2;
  endfunction

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [1:0] mark_class;
  } out_t;

  // Crosshair hit flags for one window-local position.
  typedef struct packed {
    logic arm;
    logic contour;
  } arm_hit_t;

endpackage

// ===== src/rlcb_arm_class.sv =====
// Crosshair arm and contour classification of a window-local position.
module rlcb_arm_class #(
  parameter int LENS_SIZE     = rlcb_pkg::LENS_SIZE_DEF,
  parameter int ARM_THICKNESS = rlcb_pkg::ARM_THICKNESS_DEF,
  parameter int CENTER_GAP    = rlcb_pkg::CENTER_GAP_DEF,
  parameter int EDGE_MARGIN   = rlcb_pkg::EDGE_MARGIN_DEF
) (
  input  logic signed [rlcb_pkg::coord_w(LENS_SIZE, EDGE_MARGIN, CENTER_GAP)-1:0] lx,
  input  logic signed [rlcb_pkg::coord_w(LENS_SIZE, EDGE_MARGIN, CENTER_GAP)-1:0] ly,
  output rlcb_pkg::arm_hit_t                                                      hit
);
  import rlcb_pkg::*;

  localparam int CW = coord_w(LENS_SIZE, EDGE_MARGIN, CENTER_GAP);
  localparam int C  = LENS_SIZE / 2;
  localparam int H  = ARM_THICKNESS / 2;

  // Arms in order top, bottom, left, right; each box is half open.
  localparam int BX0 [4] = '{C - H, C - H, EDGE_MARGIN, C + CENTER_GAP};
  localparam int BY0 [4] = '{EDGE_MARGIN, C + CENTER_GAP, C - H, C - H};
  localparam int BX1 [4] = '{C + H, C + H, C - CENTER_GAP, LENS_SIZE - EDGE_MARGIN};
  localparam int BY1 [4] = '{C - CENTER_GAP, LENS_SIZE - EDGE_MARGIN, C + H, C + H};

  logic [3:0] in_arm;
  logic [3:0] in_grown;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_arm[i] = (lx >= signed'(CW'(BX0[i]))) && (lx < signed'(CW'(BX1[i]))) &&
                  (ly >= signed'(CW'(BY0[i]))) && (ly < signed'(CW'(BY1[i])));
      in_grown[i] = (lx >= signed'(CW'(BX0[i] - 1))) && (lx < signed'(CW'(BX1[i] + 1))) &&
                    (ly >= signed'(CW'(BY0[i] - 1))) && (ly < signed'(CW'(BY1[i] + 1)));
    end
  end

  // Any arm wins over any contour.
  assign hit.arm     = |in_arm;
  assign hit.contour = ~(|in_arm) & (|in_grown);

endmodule

// ===== src/round_lens_crosshair_blend.sv =====
// Top level of the round lens crosshair blend pixel pipeline.
//
// Round lens crosshair blend. Each input beat carries one BGR pixel and its
// frame coordinates; each output beat carries the same pixel after a crosshair
// has been blended onto it, plus its mark class. The block is a six stage
// pipeline that takes one beat every clock as long as the output side
// is not stalled with every stage full. Stage one checks the frame
// bounds and forms window-local coordinates, stage two checks the
// window and classifies the position against the four arms and their
// contours, stage three squares the offsets from the lens center and forms
// the source share of the blend, stage four applies the circle test and adds
// the target share, stage five multiplies by the reciprocal of 255 and stage
// six corrects that quotient by one remainder compare. Valid bits travel
// with every stage; a stage holds while the one after it is full and stalled,
// so bubbles are squeezed out and in_ready only drops when every stage holds
// a beat. Configuration writes are always taken; they must only be issued
// while the pipeline is empty.
module round_lens_crosshair_blend #(
  parameter int LENS_SIZE     = rlcb_pkg::LENS_SIZE_DEF,
  parameter int ARM_THICKNESS = rlcb_pkg::ARM_THICKNESS_DEF,
  parameter int CENTER_GAP    = rlcb_pkg::CENTER_GAP_DEF,
  parameter int EDGE_MARGIN   = rlcb_pkg::EDGE_MARGIN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rlcb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rlcb_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import rlcb_pkg::*;

  localparam int CW = coord_w(LENS_SIZE, EDGE_MARGIN, CENTER_GAP);
  localparam int C  = LENS_SIZE / 2;
  // Offset from the center: the window spans -C .. LENS_SIZE-1-C.
  localparam int DW = $clog2(LENS_SIZE) + 1;
  localparam int SW = 2 * DW;

  // Configuration registers.
  logic signed [15:0] lens_left_r;
  logic signed [15:0] lens_top_r;
  logic [12:0]        frame_width_r;
  logic [12:0]        frame_height_r;
  logic [7:0]         mark_alpha_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_left_r    <= '0;
      lens_top_r     <= '0;
      frame_width_r  <= 13'd4096;
      frame_height_r <= 13'd4096;
      mark_alpha_r   <= 8'd168;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LENS_LEFT:    lens_left_r    <= cfg_data;
        CFG_LENS_TOP:     lens_top_r     <= cfg_data;
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[12:0];
        CFG_MARK_ALPHA:   mark_alpha_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the advance chain: a stage loads when it is empty
  // or when the stage after it moves on.
  logic [6:1] vld_r;
  logic [6:1] adv;

  assign adv[6] = !vld_r[6] || out_ready;
  assign adv[5] = !vld_r[5] || adv[6];
  assign adv[4] = !vld_r[4] || adv[5];
  assign adv[3] = !vld_r[3] || adv[4];
  assign adv[2] = !vld_r[2] || adv[3];
  assign adv[1] = !vld_r[1] || adv[2];
  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // The source pixel rides along stages one to five for the pass-through case.
  // Channel order is blue, green, red.
  logic [7:0] pix1_r [3];
  logic [7:0] pix2_r [3];
  logic [7:0] pix3_r [3];
  logic [7:0] pix4_r [3];
  logic [7:0] pix5_r [3];

  // Stage one: frame bounds and window-local coordinates.
  logic               in_frame_nxt;
  logic signed [17:0] lx_nxt;
  logic signed [17:0] ly_nxt;
  logic               in_frame1_r;
  logic signed [17:0] lx1_r;
  logic signed [17:0] ly1_r;

  assign in_frame_nxt = ({1'b0, in_data.pixel_x} < frame_width_r) &&
                        ({1'b0, in_data.pixel_y} < frame_height_r);
  assign lx_nxt = signed'({6'b0, in_data.pixel_x}) - signed'({{2{lens_left_r[15]}}, lens_left_r});
  assign ly_nxt = signed'({6'b0, in_data.pixel_y}) - signed'({{2{lens_top_r[15]}}, lens_top_r});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      in_frame1_r <= in_frame_nxt;
      lx1_r       <= lx_nxt;
      ly1_r       <= ly_nxt;
      pix1_r[0]   <= in_data.blue_in;
      pix1_r[1]   <= in_data.green_in;
      pix1_r[2]   <= in_data.red_in;
    end
  end

  // Stage two: window test, offsets from the center and arm classification.
  // The truncated coordinates are only meaningful inside the window, and the
  // window flag masks everything else.
  logic                 in_window_nxt;
  logic signed [DW-1:0] dx_nxt;
  logic signed [DW-1:0] dy_nxt;
  arm_hit_t             hit_nxt;
  logic                 in_zone2_r;
  logic signed [DW-1:0] dx2_r;
  logic signed [DW-1:0] dy2_r;
  arm_hit_t             hit2_r;

  assign in_window_nxt = !lx1_r[17] && (lx1_r < signed'(18'(LENS_SIZE))) &&
                         !ly1_r[17] && (ly1_r < signed'(18'(LENS_SIZE)));
  assign dx_nxt = signed'(lx1_r[DW-1:0]) - signed'(DW'(C));
  assign dy_nxt = signed'(ly1_r[DW-1:0]) - signed'(DW'(C));

  rlcb_arm_class #(
    .LENS_SIZE     (LENS_SIZE),
    .ARM_THICKNESS (ARM_THICKNESS),
    .CENTER_GAP    (CENTER_GAP),
    .EDGE_MARGIN   (EDGE_MARGIN)
  ) u_arm_class (
    .lx  (signed'(lx1_r[CW-1:0])),
    .ly  (signed'(ly1_r[CW-1:0])),
    .hit (hit_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      in_zone2_r <= in_frame1_r && in_window_nxt;
      dx2_r      <= dx_nxt;
      dy2_r      <= dy_nxt;
      hit2_r     <= hit_nxt;
      pix2_r     <= pix1_r;
    end
  end

  // Stage three: squared offsets and the source share (255 - alpha) * p.
  // The squares are formed at full width before the sign is dropped.
  logic [7:0]    inv_alpha;
  logic [SW-1:0] dx_sq_nxt;
  logic [SW-1:0] dy_sq_nxt;
  logic          in_zone3_r;
  arm_hit_t      hit3_r;
  logic [SW-1:0] dx_sq3_r;
  logic [SW-1:0] dy_sq3_r;
  logic [15:0]   src3_r [3];

  assign inv_alpha = 8'd255 - mark_alpha_r;
  assign dx_sq_nxt = unsigned'(SW'(dx2_r * dx2_r));
  assign dy_sq_nxt = unsigned'(SW'(dy2_r * dy2_r));

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      in_zone3_r <= in_zone2_r;
      hit3_r     <= hit2_r;
      dx_sq3_r   <= dx_sq_nxt;
      dy_sq3_r   <= dy_sq_nxt;
      pix3_r     <= pix2_r;
      for (int c = 0; c < 3; c++) begin
        src3_r[c] <= inv_alpha * pix2_r[c];
      end
    end
  end

  // Stage four: circle test settles the class; the target share is
  // alpha * 255 for a contour and zero for an arm.
  logic [SW:0]  dist_sq;
  logic         in_circle;
  logic [1:0]   cls_nxt;
  logic [15:0]  tgt_share;
  logic [1:0]   cls4_r;
  logic [15:0]  sum4_r [3];

  assign dist_sq   = {1'b0, dx_sq3_r} + {1'b0, dy_sq3_r};
  assign in_circle = dist_sq <= (SW+1)'(C * C);
  assign tgt_share = {mark_alpha_r, 8'd0} - {8'd0, mark_alpha_r};

  always_comb begin
    cls_nxt = MARK_NONE;
    if (in_zone3_r && in_circle) begin
      if (hit3_r.arm) begin
        cls_nxt = MARK_ARM;
      end else if (hit3_r.contour) begin
        cls_nxt = MARK_CONTOUR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      cls4_r <= cls_nxt;
      pix4_r <= pix3_r;
      for (int c = 0; c < 3; c++) begin
        sum4_r[c] <= src3_r[c] + (hit3_r.contour ? tgt_share : 16'd0);
      end
    end
  end

  // Stage five: estimate of sum / 255 as (sum * 257) >> 16, which is exact
  // or one short.
  logic [23:0] recip [3];
  logic [1:0]  cls5_r;
  logic [15:0] sum5_r [3];
  logic [7:0]  quo5_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      recip[c] = {sum4_r[c], 8'd0} + {8'd0, sum4_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      cls5_r <= cls4_r;
      pix5_r <= pix4_r;
      sum5_r <= sum4_r;
      for (int c = 0; c < 3; c++) begin
        quo5_r[c] <= recip[c][23:16];
      end
    end
  end

  // Stage six: fix the estimate with one remainder compare and pick the
  // blended or the untouched channels.
  logic [16:0] rem   [3];
  logic [7:0]  chan  [3];
  out_t        out_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[c] = {1'b0, sum5_r[c]} - {1'b0, quo5_r[c], 8'd0} + {9'd0, quo5_r[c]};
      if (cls5_r == MARK_NONE) begin
        chan[c] = pix5_r[c];
      end else if (rem[c] >= 17'd255) begin
        chan[c] = quo5_r[c] + 8'd1;
      end else begin
        chan[c] = quo5_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_r.blue_out   <= chan[0];
      out_r.green_out  <= chan[1];
      out_r.red_out    <= chan[2];
      out_r.mark_class <= cls5_r;
    end
  end

  assign out_valid = vld_r[6];
  assign out_data  = out_r;

endmodule
